### sv/cmm_pkg.sv
// Shared types, sizes, command codes and helpers for the complex matrix multiply block.
// Used by every other file of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cmm_pkg;

    // Store geometry and element width
    localparam int MAX_DIM    = 8;
    localparam int ELEM_WIDTH = 16;

    // Fixed field widths of the channels and the configuration port
    localparam int CMD_W     = 2;
    localparam int ROW_W     = 3;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 36;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    // Derived widths
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int EXT_W  = (PROD_W > OUT_W) ? PROD_W : OUT_W;

    // Item commands
    localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 2'd2;

    // Size register value after reset
    localparam logic [CFG_W-1:0] CFG_RESET_DIM = 4'd8;

    // Partial product selects of the shared multiplier, in issue order
    localparam logic [1:0] MUL_AR_BR = 2'd0;
    localparam logic [1:0] MUL_AI_BI = 2'd1;
    localparam logic [1:0] MUL_AR_BI = 2'd2;
    localparam logic [1:0] MUL_AI_BR = 2'd3;

    typedef struct packed {
        logic signed [ELEM_WIDTH-1:0] re;
        logic signed [ELEM_WIDTH-1:0] im;
    } elem_t;

    typedef struct packed {
        logic              en;
        logic              sel_b;
        logic [ADDR_W-1:0] addr;
        elem_t             data;
    } store_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
    } store_rd_t;

    typedef struct packed {
        logic       clear;
        logic       mul_en;
        logic [1:0] sel;
    } mac_ctl_t;

    // Clamp a size register into 1..MAX_DIM
    function automatic logic [DIM_W-1:0] dim_of(input logic [CFG_W-1:0] r);
        logic [DIM_W-1:0] d;
        if (r == '0)
            d = DIM_W'(1);
        else if (32'(r) > MAX_DIM)
            d = DIM_W'(MAX_DIM);
        else
            d = DIM_W'(r);
        return d;
    endfunction

    // Store entry of element (r, c)
    function automatic logic [ADDR_W-1:0] addr_of(input int unsigned r, input int unsigned c);
        return ADDR_W'(r * MAX_DIM + c);
    endfunction

endpackage

`default_nettype wire

### sv/cmm_channels.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on cmm_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cmm_item_if;
    logic                              valid;
    logic                              ready;
    logic [cmm_pkg::CMD_W-1:0]         command;
    logic [cmm_pkg::ROW_W-1:0]         elem_row;
    logic [cmm_pkg::ROW_W-1:0]         elem_col;
    logic signed [cmm_pkg::IN_W-1:0]   elem_real;
    logic signed [cmm_pkg::IN_W-1:0]   elem_imag;

    modport source (output valid, command, elem_row, elem_col, elem_real, elem_imag,
                    input ready);
    modport sink   (input valid, command, elem_row, elem_col, elem_real, elem_imag,
                    output ready);
endinterface

interface cmm_result_if;
    logic                              valid;
    logic                              ready;
    logic [cmm_pkg::ROW_W-1:0]         out_row;
    logic [cmm_pkg::ROW_W-1:0]         out_col;
    logic signed [cmm_pkg::OUT_W-1:0]  out_real;
    logic signed [cmm_pkg::OUT_W-1:0]  out_imag;
    logic                              last;

    modport source (output valid, out_row, out_col, out_real, out_imag, last,
                    input ready);
    modport sink   (input valid, out_row, out_col, out_real, out_imag, last,
                    output ready);
endinterface

`default_nettype wire

### sv/complex_matrix_multiply_top.sv
// Complex matrix multiply top level: size registers, sequencer, stores, shared MAC.
// Depends on cmm_pkg, cmm_channels, cmm_store and cmm_mac.
//
// Usage. Items arrive on the items channel. Command load A or load B writes one
// complex element at (elem_row, elem_col) into its store; loads
// give no result. Command compute emits every element of A times B in
// row-major order on the results channel, last set on the final element.
// Sizes come from the cfg_we / cfg_idx / cfg_data write port (a_rows,
// inner_size, b_cols); write them only while no compute is in progress.
// Loads are taken back to back. In a compute each inner term costs one store
// read and four passes through the single shared multiplier, and each
// element a flush and an emit step. Items are not taken while a compute
// runs. A result waits in the output register; while the receiver stalls,
// the sequencer holds at the next element until the register frees.
// Reset sets the sizes to 8 and empties the output register; the stores
// keep whatever they hold and must be loaded before a compute.
`timescale 1ns / 1ps
`default_nettype none

module complex_matrix_multiply_top (
    input  wire                               clk,
    input  wire                               rst_n,
    cmm_item_if.sink                          items,
    cmm_result_if.source                      results,
    input  wire                               cfg_we,
    input  wire [cmm_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  wire [cmm_pkg::CFG_W-1:0]          cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]                   state_reg;
    logic [2:0]                   state_next;
    logic [cmm_pkg::CFG_W-1:0]    a_rows_reg;
    logic [cmm_pkg::CFG_W-1:0]    inner_reg;
    logic [cmm_pkg::CFG_W-1:0]    b_cols_reg;
    logic [cmm_pkg::DIM_W-1:0]    i_reg;
    logic [cmm_pkg::DIM_W-1:0]    i_next;
    logic [cmm_pkg::DIM_W-1:0]    j_reg;
    logic [cmm_pkg::DIM_W-1:0]    j_next;
    logic [cmm_pkg::DIM_W-1:0]    h_reg;
    logic [cmm_pkg::DIM_W-1:0]    h_next;
    logic [1:0]                   phase_reg;
    logic [1:0]                   phase_next;
    logic [cmm_pkg::DIM_W-1:0]    rows;
    logic [cmm_pkg::DIM_W-1:0]    inner;
    logic [cmm_pkg::DIM_W-1:0]    cols;
    logic                         i_last;
    logic                         j_last;
    logic                         h_last;
    logic                         row_ok;
    logic                         load_out;
    logic                         out_valid_reg;
    logic [cmm_pkg::ROW_W-1:0]    out_row_reg;
    logic [cmm_pkg::ROW_W-1:0]    out_col_reg;
    logic [cmm_pkg::OUT_W-1:0]    out_real_reg;
    logic [cmm_pkg::OUT_W-1:0]    out_imag_reg;
    logic                         out_last_reg;

    cmm_pkg::store_wr_t           wr;
    cmm_pkg::store_rd_t           rd;
    cmm_pkg::mac_ctl_t            mac_ctl;
    cmm_pkg::elem_t               rd_a;
    cmm_pkg::elem_t               rd_b;
    logic [cmm_pkg::OUT_W-1:0]    acc_re;
    logic [cmm_pkg::OUT_W-1:0]    acc_im;

    // Size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= cmm_pkg::CFG_RESET_DIM;
            inner_reg  <= cmm_pkg::CFG_RESET_DIM;
            b_cols_reg <= cmm_pkg::CFG_RESET_DIM;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                cmm_pkg::CFG_A_ROWS: a_rows_reg <= cfg_data;
                cmm_pkg::CFG_INNER:  inner_reg  <= cfg_data;
                cmm_pkg::CFG_B_COLS: b_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign rows  = cmm_pkg::dim_of(a_rows_reg);
    assign inner = cmm_pkg::dim_of(inner_reg);
    assign cols  = cmm_pkg::dim_of(b_cols_reg);

    assign i_last = (i_reg == rows - cmm_pkg::DIM_W'(1));
    assign j_last = (j_reg == cols - cmm_pkg::DIM_W'(1));
    assign h_last = (h_reg == inner - cmm_pkg::DIM_W'(1));
    assign row_ok = (32'(items.elem_row) < cmm_pkg::MAX_DIM)
                 && (32'(items.elem_col) < cmm_pkg::MAX_DIM);

    assign items.ready = (state_reg == S_IDLE);

    // Sequencer: walk i, j and the inner index h, four multiplier passes per term
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        h_next     = h_reg;
        phase_next = phase_reg;
        load_out   = 1'b0;
        mac_ctl    = '0;
        mac_ctl.sel = phase_reg;

        wr.en       = 1'b0;
        wr.sel_b    = (items.command == cmm_pkg::CMD_LOAD_B);
        wr.addr     = cmm_pkg::addr_of(32'(items.elem_row), 32'(items.elem_col));
        wr.data.re  = cmm_pkg::ELEM_WIDTH'(items.elem_real);
        wr.data.im  = cmm_pkg::ELEM_WIDTH'(items.elem_imag);

        rd.en     = 1'b0;
        rd.addr_a = cmm_pkg::addr_of(32'(i_reg), 32'(h_reg));
        rd.addr_b = cmm_pkg::addr_of(32'(h_reg), 32'(j_reg));

        case (state_reg)
            S_IDLE:
            begin
                if (items.valid)
                begin
                    case (items.command)
                        cmm_pkg::CMD_LOAD_A, cmm_pkg::CMD_LOAD_B:
                            wr.en = row_ok;
                        cmm_pkg::CMD_COMPUTE:
                        begin
                            i_next        = '0;
                            j_next        = '0;
                            h_next        = '0;
                            mac_ctl.clear = 1'b1;
                            state_next    = S_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD:
            begin
                rd.en      = 1'b1;
                phase_next = cmm_pkg::MUL_AR_BR;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                mac_ctl.mul_en = 1'b1;
                phase_next     = phase_reg + 2'd1;
                if (phase_reg == cmm_pkg::MUL_AI_BR)
                begin
                    if (h_last)
                        state_next = S_FLUSH;
                    else
                    begin
                        h_next     = h_reg + cmm_pkg::DIM_W'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_FLUSH:
                state_next = S_EMIT;
            S_EMIT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    load_out      = 1'b1;
                    mac_ctl.clear = 1'b1;
                    h_next        = '0;
                    if (j_last)
                    begin
                        j_next = '0;
                        if (i_last)
                            state_next = S_IDLE;
                        else
                        begin
                            i_next     = i_reg + cmm_pkg::DIM_W'(1);
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + cmm_pkg::DIM_W'(1);
                        state_next = S_RD;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Sequencer registers and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            h_reg         <= '0;
            phase_reg     <= cmm_pkg::MUL_AR_BR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            h_reg     <= h_next;
            phase_reg <= phase_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Capture a finished element
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_row_reg  <= cmm_pkg::ROW_W'(i_reg);
            out_col_reg  <= cmm_pkg::ROW_W'(j_reg);
            out_real_reg <= acc_re;
            out_imag_reg <= acc_im;
            out_last_reg <= i_last && j_last;
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.out_row  = out_row_reg;
    assign results.out_col  = out_col_reg;
    assign results.out_real = out_real_reg;
    assign results.out_imag = out_imag_reg;
    assign results.last     = out_last_reg;

    cmm_store u_store (
        .clk  (clk),
        .wr   (wr),
        .rd   (rd),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    cmm_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .a      (rd_a),
        .b      (rd_b),
        .acc_re (acc_re),
        .acc_im (acc_im)
    );

endmodule

`default_nettype wire

### sv/cmm_store.sv
// Element stores for matrices A and B: one write port, one registered read per store.
// Depends on cmm_pkg for the entry type and the port structs.
`timescale 1ns / 1ps
`default_nettype none

module cmm_store (
    input  wire                 clk,
    input  cmm_pkg::store_wr_t  wr,
    input  cmm_pkg::store_rd_t  rd,
    output cmm_pkg::elem_t      rd_a,
    output cmm_pkg::elem_t      rd_b
);

    cmm_pkg::elem_t mem_a [cmm_pkg::DEPTH];
    cmm_pkg::elem_t mem_b [cmm_pkg::DEPTH];
    cmm_pkg::elem_t rd_a_reg;
    cmm_pkg::elem_t rd_b_reg;

    // Write and read store A
    always_ff @(posedge clk)
    begin
        if (wr.en && !wr.sel_b)
            mem_a[wr.addr] <= wr.data;
        if (rd.en)
            rd_a_reg <= mem_a[rd.addr_a];
    end

    // Write and read store B
    always_ff @(posedge clk)
    begin
        if (wr.en && wr.sel_b)
            mem_b[wr.addr] <= wr.data;
        if (rd.en)
            rd_b_reg <= mem_b[rd.addr_b];
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

`default_nettype wire

### sv/cmm_mac.sv
// Shared complex multiply-accumulate unit: one real multiplier, four passes per term.
// Depends on cmm_pkg for the operand type, selects and widths.
`timescale 1ns / 1ps
`default_nettype none

module cmm_mac (
    input  wire                           clk,
    input  wire                           rst_n,
    input  cmm_pkg::mac_ctl_t             ctl,
    input  cmm_pkg::elem_t                a,
    input  cmm_pkg::elem_t                b,
    output logic [cmm_pkg::OUT_W-1:0]     acc_re,
    output logic [cmm_pkg::OUT_W-1:0]     acc_im
);

    logic signed [cmm_pkg::ELEM_WIDTH-1:0] op_x;
    logic signed [cmm_pkg::ELEM_WIDTH-1:0] op_y;
    logic signed [cmm_pkg::PROD_W-1:0]     prod_next;
    logic signed [cmm_pkg::PROD_W-1:0]     prod_reg;
    logic signed [cmm_pkg::EXT_W-1:0]      prod_ext;
    logic [cmm_pkg::OUT_W-1:0]             term;
    logic                                  pend_reg;
    logic [1:0]                            pend_sel_reg;
    logic [cmm_pkg::OUT_W-1:0]             acc_re_reg;
    logic [cmm_pkg::OUT_W-1:0]             acc_im_reg;
    logic [cmm_pkg::OUT_W-1:0]             acc_re_next;
    logic [cmm_pkg::OUT_W-1:0]             acc_im_next;

    // Pick the operand pair for this pass
    always_comb
    begin
        case (ctl.sel)
            cmm_pkg::MUL_AR_BR:
            begin
                op_x = a.re;
                op_y = b.re;
            end
            cmm_pkg::MUL_AI_BI:
            begin
                op_x = a.im;
                op_y = b.im;
            end
            cmm_pkg::MUL_AR_BI:
            begin
                op_x = a.re;
                op_y = b.im;
            end
            default:
            begin
                op_x = a.im;
                op_y = b.re;
            end
        endcase
    end

    assign prod_next = cmm_pkg::PROD_W'(op_x) * cmm_pkg::PROD_W'(op_y);
    assign prod_ext  = cmm_pkg::EXT_W'(prod_reg);
    assign term      = prod_ext[cmm_pkg::OUT_W-1:0];

    // Clear both sums, or fold the registered product into the matching accumulator
    always_comb
    begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        if (ctl.clear)
        begin
            acc_re_next = '0;
            acc_im_next = '0;
        end
        else if (pend_reg)
        begin
            case (pend_sel_reg)
                cmm_pkg::MUL_AR_BR: acc_re_next = acc_re_reg + term;
                cmm_pkg::MUL_AI_BI: acc_re_next = acc_re_reg - term;
                default:            acc_im_next = acc_im_reg + term;
            endcase
        end
    end

    // Track the product in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= 1'b0;
            pend_sel_reg <= cmm_pkg::MUL_AR_BR;
        end
        else
        begin
            pend_reg     <= ctl.mul_en;
            pend_sel_reg <= ctl.sel;
        end
    end

    // Hold product and sums
    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        acc_re_reg <= acc_re_next;
        acc_im_reg <= acc_im_next;
    end

    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;

endmodule

`default_nettype wire

### sv/cmm_checker.sv
// Port-level assertions for the complex matrix multiply top, attached by bind.
// Depends on cmm_pkg for the command codes and widths.
`timescale 1ns / 1ps
`default_nettype none

module cmm_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          in_valid,
    input wire                          in_ready,
    input wire [cmm_pkg::CMD_W-1:0]     command,
    input wire                          out_valid,
    input wire                          out_ready,
    input wire [cmm_pkg::ROW_W-1:0]     out_row,
    input wire [cmm_pkg::ROW_W-1:0]     out_col,
    input wire                          last
);

    // A compute beat makes the block busy on the next cycle
    compute_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && command == cmm_pkg::CMD_COMPUTE) |=> !in_ready)
        else $error("items still ready right after a compute beat");

    // A load beat never stalls the following item
    load_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready
         && (command == cmm_pkg::CMD_LOAD_A || command == cmm_pkg::CMD_LOAD_B))
        |=> in_ready)
        else $error("items not ready after a load beat");

    // A stalled result holds
    result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_row)
                                       && $stable(out_col) && $stable(last)))
        else $error("stalled result changed");

    // Result indexes stay inside the matrix
    result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(out_row) < cmm_pkg::MAX_DIM && 32'(out_col) < cmm_pkg::MAX_DIM))
        else $error("result index outside the matrix");

endmodule

bind complex_matrix_multiply_top cmm_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .command   (items.command),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_row   (results.out_row),
    .out_col   (results.out_col),
    .last      (results.last)
);

`default_nettype wire
